// ===== hdl/rsq_pkg.sv =====
// Shared types and constants for the reciprocal square root pipeline.
// No dependencies; imported by every module under hdl/.
package rsq_pkg;

  localparam logic [31:0] RSQ_MAGIC     = 32'h5f3759df;
  localparam logic [31:0] F32_ONE_HALF3 = 32'h3fc00000;  // 1.5
  localparam logic [31:0] F32_THRESHOLD = 32'h2b8cbccc;  // 1.0e-12
  localparam logic [31:0] F32_POS_INF   = 32'h7f800000;
  localparam logic [7:0]  F32_EXP_MAX   = 8'hff;

  // Sideband that rides along with every beat through the arithmetic units.
  typedef struct packed {
    logic [31:0] y;      // current estimate
    logic [31:0] xh;     // half of the input value
    logic        kill;   // input negative, at or below threshold, or NaN: result is +0.0
    logic        last;
  } rsq_side_t;

endpackage

// ===== hdl/rsq_fmul.sv =====
// Two-stage binary32 multiplier, round to nearest even, with sideband.
// Depends on rsq_pkg. A zero exponent field reads as zero, an all-ones one as infinite.
module rsq_fmul (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  input  rsq_pkg::rsq_side_t in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       p,
  output rsq_pkg::rsq_side_t out_side
);
  import rsq_pkg::*;

  logic        v1, v2, en1, en2;
  logic [47:0] prod;
  logic [8:0]  esum;
  logic        sgn1, inf1, zero1;
  rsq_side_t   side1;

  logic        hi, g, st, up;
  logic [22:0] mant;
  logic [23:0] mr;
  logic signed [10:0] e;
  logic [31:0] p_next;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Stage 1: product of the significands, exponent sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      prod  <= {1'b1, a[22:0]} * {1'b1, b[22:0]};
      esum  <= {1'b0, a[30:23]} + {1'b0, b[30:23]};
      sgn1  <= a[31] ^ b[31];
      inf1  <= (a[30:23] == F32_EXP_MAX) || (b[30:23] == F32_EXP_MAX);
      zero1 <= (a[30:23] == 8'd0) || (b[30:23] == 8'd0);
      side1 <= in_side;
    end
  end

  // Stage 2: normalize and round.
  always_comb begin
    hi   = prod[47];
    mant = hi ? prod[46:24] : prod[45:23];
    g    = hi ? prod[23] : prod[22];
    st   = hi ? |prod[22:0] : |prod[21:0];
    up   = g & (st | mant[0]);
    mr   = {1'b0, mant} + {23'd0, up};
    e    = $signed({2'b00, esum}) - 11'sd127 + $signed({10'd0, hi}) +
           $signed({10'd0, mr[23]});
    if (inf1) begin
      p_next = {sgn1, F32_POS_INF[30:0]};
    end else if (zero1 || e <= 11'sd0) begin
      p_next = {sgn1, 31'd0};
    end else if (e >= 11'sd255) begin
      p_next = {sgn1, F32_POS_INF[30:0]};
    end else begin
      p_next = {sgn1, e[7:0], (mr[23] ? 23'd0 : mr[22:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      p        <= p_next;
      out_side <= side1;
    end
  end

  assign out_valid = v2;

endmodule

// ===== hdl/rsq_fsub.sv =====
// Two-stage binary32 unit computing 1.5 - b, round to nearest even.
// Depends on rsq_pkg. The sign of b is ignored: b is taken as normal, zero or +inf.
module rsq_fsub (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       b,
  input  rsq_pkg::rsq_side_t in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       r,
  output rsq_pkg::rsq_side_t out_side
);
  import rsq_pkg::*;

  logic        v1, v2, en1, en2;
  logic        swap, sgn1, inf1;
  logic [31:0] big, sml;
  logic [7:0]  d;
  logic [49:0] ext, sh;
  logic        sticky;
  logic [26:0] big_m, sml_m;
  logic [7:0]  ebig;
  rsq_side_t   side1;

  logic [26:0] diff, norm;
  logic [4:0]  lz;
  logic        g, st, up;
  logic [24:0] mr;
  logic signed [9:0] e;
  logic [31:0] r_next;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Stage 1: order by magnitude and align the smaller operand.
  always_comb begin
    swap = b[30:0] > F32_ONE_HALF3[30:0];
    big  = swap ? b : F32_ONE_HALF3;
    sml  = swap ? F32_ONE_HALF3 : b;
    d    = big[30:23] - sml[30:23];
    ext  = (sml[30:23] == 8'd0) ? 50'd0 : {1'b1, sml[22:0], 26'd0};
    sh   = (d > 8'd49) ? 50'd0 : (ext >> d[5:0]);
    sticky = ((d > 8'd49) && (sml[30:23] != 8'd0)) || (|sh[22:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      big_m <= {1'b1, big[22:0], 3'b000};
      sml_m <= {sh[49:24], sh[23] | sticky};
      ebig  <= big[30:23];
      sgn1  <= swap;
      inf1  <= b[30:23] == F32_EXP_MAX;
      side1 <= in_side;
    end
  end

  // Stage 2: subtract, normalize, round.
  always_comb begin
    diff = big_m - sml_m;
    lz   = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (diff[i]) begin
        lz = 5'(26 - i);
      end
    end
    norm = diff << lz;
    g    = norm[2];
    st   = |norm[1:0];
    up   = g & (st | norm[3]);
    mr   = {1'b0, norm[26:3]} + {24'd0, up};
    e    = $signed({2'b00, ebig}) - $signed({5'd0, lz}) + $signed({9'd0, mr[24]});
    if (inf1) begin
      r_next = {1'b1, F32_POS_INF[30:0]};
    end else if (diff == 27'd0 || e <= 10'sd0) begin
      r_next = 32'd0;
    end else begin
      r_next = {sgn1, e[7:0], (mr[24] ? 23'd0 : mr[22:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      r        <= r_next;
      out_side <= side1;
    end
  end

  assign out_valid = v2;

endmodule

// ===== hdl/rsq_newton.sv =====
// One Newton step y = y * (1.5 - (xh * y) * y) as an eight-stage pipeline.
// Depends on rsq_pkg, rsq_fmul and rsq_fsub.
module rsq_newton (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsq_pkg::rsq_side_t in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output rsq_pkg::rsq_side_t out_side
);
  import rsq_pkg::*;

  logic        v1, v2, v3, rd1, rd2, rd3;
  logic [31:0] t1, t2, t3, y4;
  rsq_side_t   s1, s2, s3, s4;

  rsq_fmul u_mul_xy (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .a(in_side.xh), .b(in_side.y), .in_side(in_side),
    .out_valid(v1), .out_ready(rd1), .p(t1), .out_side(s1)
  );

  rsq_fmul u_mul_ty (
    .clk(clk), .rst(rst), .in_valid(v1), .in_ready(rd1),
    .a(t1), .b(s1.y), .in_side(s1),
    .out_valid(v2), .out_ready(rd2), .p(t2), .out_side(s2)
  );

  rsq_fsub u_sub (
    .clk(clk), .rst(rst), .in_valid(v2), .in_ready(rd2),
    .b(t2), .in_side(s2),
    .out_valid(v3), .out_ready(rd3), .r(t3), .out_side(s3)
  );

  rsq_fmul u_mul_yt (
    .clk(clk), .rst(rst), .in_valid(v3), .in_ready(rd3),
    .a(s3.y), .b(t3), .in_side(s3),
    .out_valid(out_valid), .out_ready(out_ready), .p(y4), .out_side(s4)
  );

  // Replace the estimate, keep the rest of the sideband.
  always_comb begin
    out_side   = s4;
    out_side.y = y4;
  end

endmodule

// ===== hdl/fast_inverse_sqrt_f32_unit.sv =====
// Top level of the binary32 reciprocal square root pipeline.
// Depends on rsq_pkg, rsq_newton (and through it rsq_fmul, rsq_fsub).
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   input   | in_valid, in_stall, x_bits, last_in   | beat in
//   output  | out_valid, out_stall, y_bits, last_out | beat out
//
// One beat enters per cycle while in_stall is low; each beat passes through one
// prepare stage and then two Newton steps, each of four two-stage
// arithmetic units (multiply, multiply, subtract, multiply).
// Reset (rst, synchronous) clears every stage valid bit; payload registers
// are not reset.
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles collapse under out_stall and input beats keep flowing until the
// pipeline is full; a held output beat does not change.
module fast_inverse_sqrt_f32_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] x_bits,
  input  logic        last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] y_bits,
  output logic        last_out
);
  import rsq_pkg::*;

  logic      v0, en0, rd1, v1, rd2;
  rsq_side_t s0, s1, s2;
  logic      kill_next;
  logic [31:0] xh_next;

  assign en0      = !v0 || rd1;
  assign in_stall = !en0;

  // Flag inputs at or below the threshold, negatives and NaN; positive
  // values order like their unsigned bit patterns.
  always_comb begin
    kill_next = x_bits[31] || (x_bits <= F32_THRESHOLD) ||
                ((x_bits[30:23] == F32_EXP_MAX) && (x_bits[22:0] != 23'd0));
    // Halve by dropping the exponent; the exponent is large enough here.
    xh_next = (x_bits[30:23] == F32_EXP_MAX) ? x_bits :
              {x_bits[31], x_bits[30:23] - 8'd1, x_bits[22:0]};
  end

  // Prepare stage: half value and the first guess from the magic constant.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= in_valid;
    end
    if (en0) begin
      s0.y    <= RSQ_MAGIC - {1'b0, x_bits[31:1]};
      s0.xh   <= xh_next;
      s0.kill <= kill_next;
      s0.last <= last_in;
    end
  end

  rsq_newton u_step1 (
    .clk(clk), .rst(rst), .in_valid(v0), .in_ready(rd1), .in_side(s0),
    .out_valid(v1), .out_ready(rd2), .out_side(s1)
  );

  rsq_newton u_step2 (
    .clk(clk), .rst(rst), .in_valid(v1), .in_ready(rd2), .in_side(s1),
    .out_valid(out_valid), .out_ready(!out_stall), .out_side(s2)
  );

  // Drop the estimate for flagged beats: the result is +0.0.
  assign y_bits   = s2.kill ? 32'd0 : s2.y;
  assign last_out = s2.last;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the binary32 fast reciprocal square root pipeline.
// Depends on rsq_pkg and fast_inverse_sqrt_f32_unit; predicts each beat with
// bit-exact single precision arithmetic built from integer operations.
`timescale 1ns / 100ps

module testbench;
  import rsq_pkg::*;

  localparam logic [31:0] F32_HALF  = 32'h3f000000;  // 0.5
  localparam logic [31:0] F32_QNAN  = 32'h7fc00000;
  localparam int          DRAIN_CYC = 40;

  typedef struct {
    logic [31:0] y;
    logic        last;
  } rsq_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] x_bits;
  logic        last_in;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] y_bits;
  logic        last_out;

  rsq_result_t pending_y[$];   // predicted results, oldest first
  int          error_count;
  int          tx_idle_pct;    // chance (percent) the sender skips a cycle
  int          rx_stall_pct;   // chance (percent) the receiver stalls a cycle

  fast_inverse_sqrt_f32_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .x_bits   (x_bits),
    .last_in  (last_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .y_bits   (y_bits),
    .last_out (last_out)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ------------------------------------------------------------------
  // Single precision arithmetic, round to nearest even, full subnormal
  // support. A value is carried as an unsigned integer significand m and
  // a power-of-two scale e, so that value = m * 2^e.
  // ------------------------------------------------------------------

  // Split a finite nonzero binary32 into significand and scale.
  function automatic void f32_unpack(input logic [31:0] f, output longint unsigned m,
                                     output int e);
    if (f[30:23] == 8'd0) begin
      m = {41'd0, f[22:0]};
      e = -149;
    end else begin
      m = {40'd0, 1'b1, f[22:0]};
      e = int'(f[30:23]) - 150;
    end
  endfunction

  // Round m * 2^e to binary32; bit 0 of m may carry a sticky bit.
  function automatic logic [31:0] f32_round_pack(input logic sgn, input longint unsigned m,
                                                 input int e);
    int              msb;
    int              sh;
    int              be;
    longint unsigned keep;
    longint unsigned rem;
    longint unsigned half;
    msb = 0;
    for (int i = 0; i < 64; i++)
      if (m[i]) msb = i;
    // Shift so the significand is 24 bits, or stop at the subnormal scale.
    sh = msb - 23;
    if (sh < -149 - e) sh = -149 - e;
    if (sh > 63) begin
      return {sgn, 31'd0};
    end else if (sh > 0) begin
      keep = m >> sh;
      rem  = m - (keep << sh);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 1;
    end else begin
      keep = m << (-sh);
    end
    if (keep == (64'd1 << 24)) begin
      keep = keep >> 1;
      sh   = sh + 1;
    end
    be = sh + e + 150;
    if (keep < (64'd1 << 23)) be = 0;
    if (be >= 255) return {sgn, F32_POS_INF[30:0]};
    return {sgn, be[7:0], keep[22:0]};
  endfunction

  function automatic logic f32_is_nan(input logic [31:0] f);
    return f[30:23] == F32_EXP_MAX && f[22:0] != 23'd0;
  endfunction

  function automatic logic f32_is_inf(input logic [31:0] f);
    return f[30:0] == F32_POS_INF[30:0];
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    logic            sgn;
    longint unsigned ma;
    longint unsigned mb;
    int              ea;
    int              eb;
    sgn = a[31] ^ b[31];
    if (f32_is_nan(a) || f32_is_nan(b)) return F32_QNAN;
    if (f32_is_inf(a) || f32_is_inf(b)) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return F32_QNAN;
      return {sgn, F32_POS_INF[30:0]};
    end
    if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
    f32_unpack(a, ma, ea);
    f32_unpack(b, mb, eb);
    return f32_round_pack(sgn, ma * mb, ea + eb);
  endfunction

  // a - b
  function automatic logic [31:0] f32_sub(input logic [31:0] a, input logic [31:0] b_in);
    logic [31:0]     b;
    logic [31:0]     tmp;
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned big;
    longint unsigned lil;
    longint unsigned res;
    logic            sgn;
    int              ea;
    int              eb;
    int              d;
    b = {~b_in[31], b_in[30:0]};
    if (f32_is_nan(a) || f32_is_nan(b)) return F32_QNAN;
    if (f32_is_inf(a) && f32_is_inf(b) && a[31] != b[31]) return F32_QNAN;
    if (f32_is_inf(a)) return a;
    if (f32_is_inf(b)) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 31'd0) return b;
    if (b[30:0] == 31'd0) return a;
    // Put the larger magnitude in a.
    if (b[30:0] > a[30:0]) begin
      tmp = a;
      a   = b;
      b   = tmp;
    end
    f32_unpack(a, ma, ea);
    f32_unpack(b, mb, eb);
    d   = ea - eb;
    big = ma << 30;
    lil = mb << 30;
    if (d > 62) begin
      lil = 64'd1;
    end else if (d > 0) begin
      lil = (lil >> d) | 64'((lil & ((64'd1 << d) - 1)) != 0);
    end
    sgn = a[31];
    if (a[31] == b[31]) res = big + lil;
    else res = big - lil;
    if (res == 0) return 32'd0;
    return f32_round_pack(sgn, res, ea - 30);
  endfunction

  function automatic logic [31:0] newton_refine(input logic [31:0] y, input logic [31:0] xh);
    logic [31:0] t;
    t = f32_mul(xh, y);
    t = f32_mul(t, y);
    t = f32_sub(F32_ONE_HALF3, t);
    return f32_mul(y, t);
  endfunction

  function automatic logic [31:0] rsqrt_predict(input logic [31:0] xb);
    logic [31:0] xh;
    logic [31:0] y;
    // Drop negatives, NaN and anything at or below the threshold to +0.0.
    if (xb[31] || xb <= F32_THRESHOLD || xb > F32_POS_INF) return 32'd0;
    xh = f32_mul(F32_HALF, xb);
    y  = RSQ_MAGIC - (xb >> 1);
    y  = newton_refine(y, xh);
    return newton_refine(y, xh);
  endfunction

  // ------------------------------------------------------------------
  // Beat traffic
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("ERROR t=%0t %s", $realtime, what);
    error_count++;
  endtask

  // Send one beat; idle first at random, then hold the payload until taken.
  task automatic send_beat(input logic [31:0] xb, input logic lst);
    rsq_result_t exp_r;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      x_bits   <= $urandom;
      last_in  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_bits   <= xb;
    last_in  <= lst;
    do @(posedge clk); while (in_stall);
    exp_r.y    = rsqrt_predict(xb);
    exp_r.last = lst;
    pending_y.push_back(exp_r);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (pending_y.size() != 0) @(posedge clk);
  endtask

  // Randomize the receiver's stall every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Compare every output beat against the oldest prediction.
  always @(posedge clk) begin
    rsq_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_y.size() == 0) begin
        report_mismatch($sformatf("unexpected beat y=%h last=%b", y_bits, last_out));
      end else begin
        exp_r = pending_y.pop_front();
        if (y_bits !== exp_r.y)
          report_mismatch($sformatf("y_bits %h, predicted %h", y_bits, exp_r.y));
        if (last_out !== exp_r.last)
          report_mismatch($sformatf("last_out %b, predicted %b", last_out, exp_r.last));
      end
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Hit the edges: threshold, zeros, signs, NaN, subnormals, infinities.
  task automatic test_corner_values();
    logic [31:0] corners[$];
    corners = '{32'h00000000, 32'h80000000, 32'hbf800000, 32'h7fc00000, 32'hffffffff,
                32'h7f800001, 32'h00000001, 32'h007fffff, F32_THRESHOLD,
                F32_THRESHOLD + 1, F32_THRESHOLD - 1, 32'h3f800000, 32'h40800000,
                32'h3e800000, 32'h7f7fffff, F32_POS_INF, 32'hff800000, 32'h00800000,
                32'h5f3759df, 32'h7fffffff, 32'h3f7fffff, 32'h4b000001};
    foreach (corners[i])
      send_beat(corners[i], i[0]);
    wait_drained();
  endtask

  // Mostly valid positive operands across the exponent range, some raw noise.
  task automatic test_random_stream(input int n_beats);
    logic [31:0] xb;
    int          pick;
    for (int i = 0; i < n_beats; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)
        xb = {1'b0, 8'($urandom_range(254, 1)), 23'($urandom)};
      else if (pick < 55)
        xb = F32_THRESHOLD + $urandom_range(64) - 32;
      else if (pick < 62)
        xb = {1'b0, 8'($urandom_range(254, 240)), 23'($urandom)};
      else
        xb = $urandom;
      send_beat(xb, 1'($urandom_range(1)));
    end
    release_input();
  endtask

  initial begin
    error_count  = 0;
    tx_idle_pct  = 38;
    rx_stall_pct = 58;
    rst          = 1'b1;
    in_valid     = 1'b0;
    x_bits       = 32'd0;
    last_in      = 1'b0;
    out_stall    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_values();
    test_random_stream(200);
    // Hold off until the pipe is empty before flipping the pressure.
    wait_drained();
    tx_idle_pct  = 58;
    rx_stall_pct = 38;
    test_random_stream(200);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    test_random_stream(200);

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (error_count == 0)
      $display("fast_inverse_sqrt_f32_unit: match");
    else
      $display("fast_inverse_sqrt_f32_unit: mismatch");
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #(12 * 400000);
    $display("fast_inverse_sqrt_f32_unit: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rsq_pkg.sv
hdl/rsq_fmul.sv
hdl/rsq_fsub.sv
hdl/rsq_newton.sv
hdl/fast_inverse_sqrt_f32_unit.sv
bench/testbench.sv
